// ----- design/ils_pkg.sv -----
// ----------------------------------------------------------------------------
// ils_pkg: shared definitions for the indexed list store
// Field widths, command and status codes, controller states and the
// command/status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int CMD_W            = 3;
   localparam int POS_W            = 9;
   localparam int DATA_W           = 32;
   localparam int STATUS_W         = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_READ     = 3'd0,
      CMD_INS_HEAD = 3'd1,
      CMD_INS_TAIL = 3'd2,
      CMD_INS_POS  = 3'd3,
      CMD_DELETE   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // What the captured command turns out to need, given the current count.
   typedef enum logic [2:0] {
      OUT_READ,
      OUT_REJECT,
      OUT_APPEND,
      OUT_SHIFT_UP,
      OUT_TRIM,
      OUT_SHIFT_DOWN
   } outcome_type;

   typedef enum logic [1:0] {
      RES_DECODE,
      RES_MEM,
      RES_DONE
   } res_sel_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_READ_WAIT,
      S_UP,
      S_PLACE,
      S_DOWN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        capture;
      logic        read_pos;
      logic        begin_up;
      logic        step_up;
      logic        place;
      logic        begin_down;
      logic        step_down;
      logic        drop_last;
      logic        set_result;
      res_sel_type res_sel;
      logic        load_out;
   } ctrl_type;

   typedef struct packed {
      outcome_type outcome;
      logic        up_last;
      logic        down_last;
      logic        out_free;
   } stat_type;

endpackage

// ----- design/ils_channels.sv -----
// ----------------------------------------------------------------------------
// ils_channels: request and response channel interfaces
// Valid/ready channels carrying the command and the result of one
// transaction each.
// ----------------------------------------------------------------------------
interface ils_req_if;
   import ils_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, cmd, position, value, input ready);
   modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface ils_rsp_if;
   import ils_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] read_value;
   logic [STATUS_W-1:0]      status;

   modport source (output valid, read_value, status, input ready);
   modport sink   (input valid, read_value, status, output ready);
endinterface

// ----- design/ils_datapath.sv -----
// ----------------------------------------------------------------------------
// ils_datapath: element memory, count and result registers
// Decodes the captured command against the count, moves entries one per
// cycle through the memory and holds the response in an output register.
// ----------------------------------------------------------------------------
module ils_datapath #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ils_pkg::CMD_W-1:0]        req_cmd,
   input  logic [ils_pkg::POS_W-1:0]        req_position,
   input  logic signed [ils_pkg::DATA_W-1:0] req_value,
   input  ils_pkg::ctrl_type                ctrl,
   output ils_pkg::stat_type                stat,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [ils_pkg::DATA_W-1:0] rsp_read_value,
   output logic [ils_pkg::STATUS_W-1:0]     rsp_status
);
   import ils_pkg::*;

   localparam int AW   = $clog2(CAPACITY);
   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

   logic [DATA_W-1:0] mem [CAPACITY];

   logic [CMD_W-1:0]  cmd_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] value_ff;
   logic [CW-1:0]     cnt_ff;
   logic [AW-1:0]     idx_ff;
   logic [DATA_W-1:0] rdata_ff;
   logic [DATA_W-1:0] res_value_ff;
   status_type        res_status_ff;
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_value_ff;
   status_type        out_status_ff;

   logic [CMPW-1:0]   pos_cmp;
   logic [CMPW-1:0]   cnt_cmp;
   logic [AW-1:0]     pos_addr;
   logic [AW-1:0]     cnt_addr;
   logic              full;
   outcome_type       outcome;
   logic [DATA_W-1:0] rej_value;
   status_type        rej_status;
   logic [AW-1:0]     target;

   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;

   assign pos_cmp  = CMPW'(pos_ff);
   assign cnt_cmp  = CMPW'(cnt_ff);
   assign pos_addr = pos_cmp[AW-1:0];
   assign cnt_addr = cnt_ff[AW-1:0];
   assign full     = (cnt_ff == CAP_COUNT);

   always_comb begin
      outcome    = OUT_REJECT;
      rej_value  = '0;
      rej_status = ST_DONE;
      target     = '0;
      case (cmd_ff)
         CMD_READ: begin
            if (pos_cmp >= cnt_cmp) begin
               rej_value  = '1;
               rej_status = ST_RANGE;
            end else begin
               outcome = OUT_READ;
            end
         end
         CMD_INS_HEAD, CMD_INS_TAIL: begin
            if (full) begin
               rej_status = ST_FULL;
            end else begin
               target  = (cmd_ff == CMD_INS_HEAD) ? '0 : cnt_addr;
               outcome = (target == cnt_addr) ? OUT_APPEND : OUT_SHIFT_UP;
            end
         end
         CMD_INS_POS: begin
            if (pos_cmp > cnt_cmp) begin
               rej_status = ST_RANGE;
            end else if (full) begin
               rej_status = ST_FULL;
            end else begin
               target  = pos_addr;
               outcome = (target == cnt_addr) ? OUT_APPEND : OUT_SHIFT_UP;
            end
         end
         CMD_DELETE: begin
            if (pos_cmp >= cnt_cmp) begin
               rej_status = ST_RANGE;
            end else if ((pos_cmp + CMPW'(1)) == cnt_cmp) begin
               outcome = OUT_TRIM;
            end else begin
               outcome = OUT_SHIFT_DOWN;
            end
         end
         default: begin
            outcome = OUT_REJECT;
         end
      endcase
   end

   assign stat.outcome   = outcome;
   assign stat.up_last   = (idx_ff == (target + AW'(1)));
   assign stat.down_last = ((CW'(idx_ff) + CW'(2)) == cnt_ff);
   assign stat.out_free  = !out_valid_ff || rsp_ready;

   // Memory port control: reads run one entry ahead of the writes.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = rdata_ff;
      if (ctrl.read_pos) begin
         rd_en   = 1'b1;
         rd_addr = pos_addr;
      end
      if (ctrl.begin_up) begin
         rd_en   = 1'b1;
         rd_addr = cnt_addr - AW'(1);
      end
      if (ctrl.step_up) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         rd_en   = 1'b1;
         rd_addr = idx_ff - AW'(2);
      end
      if (ctrl.place) begin
         wr_en   = 1'b1;
         wr_addr = target;
         wr_data = value_ff;
      end
      if (ctrl.begin_down) begin
         rd_en   = 1'b1;
         rd_addr = pos_addr + AW'(1);
      end
      if (ctrl.step_down) begin
         wr_en   = 1'b1;
         wr_addr = idx_ff;
         rd_en   = 1'b1;
         rd_addr = idx_ff + AW'(2);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff   <= req_cmd;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (ctrl.begin_up) begin
         idx_ff <= cnt_addr;
      end else if (ctrl.step_up) begin
         idx_ff <= idx_ff - AW'(1);
      end else if (ctrl.begin_down) begin
         idx_ff <= pos_addr;
      end else if (ctrl.step_down) begin
         idx_ff <= idx_ff + AW'(1);
      end
      if (ctrl.set_result) begin
         case (ctrl.res_sel)
            RES_DECODE: begin
               res_value_ff  <= rej_value;
               res_status_ff <= rej_status;
            end
            RES_MEM: begin
               res_value_ff  <= rdata_ff;
               res_status_ff <= ST_DONE;
            end
            default: begin
               res_value_ff  <= '0;
               res_status_ff <= ST_DONE;
            end
         endcase
      end
      if (ctrl.load_out) begin
         out_value_ff  <= res_value_ff;
         out_status_ff <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ctrl.place) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (ctrl.drop_last) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
         if (ctrl.load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_read_value = out_value_ff;
   assign rsp_status     = out_status_ff;

endmodule

// ----- design/ils_controller.sv -----
// ----------------------------------------------------------------------------
// ils_controller: command sequencer for the indexed list store
// Steps one transaction through decode, entry moves and the hand-over of
// its result to the output register.
// ----------------------------------------------------------------------------
module ils_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ils_pkg::stat_type stat,
   output ils_pkg::ctrl_type ctrl
);
   import ils_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            case (stat.outcome)
               OUT_READ:       state_in = S_READ_WAIT;
               OUT_SHIFT_UP:   state_in = S_UP;
               OUT_SHIFT_DOWN: state_in = S_DOWN;
               default:        state_in = S_FINISH;
            endcase
         end
         S_READ_WAIT: state_in = S_FINISH;
         S_UP: begin
            if (stat.up_last) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: state_in = S_FINISH;
         S_DOWN: begin
            if (stat.down_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      ctrl.res_sel = RES_DONE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
         end
         S_CHECK: begin
            case (stat.outcome)
               OUT_READ: ctrl.read_pos = 1'b1;
               OUT_APPEND: begin
                  ctrl.place      = 1'b1;
                  ctrl.set_result = 1'b1;
               end
               OUT_SHIFT_UP: ctrl.begin_up = 1'b1;
               OUT_TRIM: begin
                  ctrl.drop_last  = 1'b1;
                  ctrl.set_result = 1'b1;
               end
               OUT_SHIFT_DOWN: ctrl.begin_down = 1'b1;
               default: begin
                  ctrl.set_result = 1'b1;
                  ctrl.res_sel    = RES_DECODE;
               end
            endcase
         end
         S_READ_WAIT: begin
            ctrl.set_result = 1'b1;
            ctrl.res_sel    = RES_MEM;
         end
         S_UP: ctrl.step_up = 1'b1;
         S_PLACE: begin
            ctrl.place      = 1'b1;
            ctrl.set_result = 1'b1;
         end
         S_DOWN: begin
            ctrl.step_down = 1'b1;
            if (stat.down_last) begin
               ctrl.drop_last  = 1'b1;
               ctrl.set_result = 1'b1;
            end
         end
         S_FINISH: ctrl.load_out = stat.out_free;
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/indexed_list_store.sv -----
// ----------------------------------------------------------------------------
// indexed_list_store: ordered list of signed 32-bit values
// A list of up to CAPACITY entries kept in a memory indexed by position,
// with read, insert (head, tail, position) and delete commands.
// ----------------------------------------------------------------------------
//
//   Channel    Role     Carries
//   ---------  -------  ---------------------------------------------------
//   req_chan   sink     cmd (3 b), position (9 b), value (32 b signed)
//   rsp_chan   source   read_value (32 b signed), status (2 b)
//
// One transaction is worked at a time. A read is decoded against the
// count while its entry is read; the value is then taken into the result
// register and handed on to the output register. An insert that moves
// entries moves them up one at a time (count minus the insert position in
// all) and then places the new value. A delete moves entries down one at a
// time (count minus position minus one in all). The element memory has one
// read and one write port and so moves one entry per cycle. An append at
// the tail, and rejected and unknown commands, go from decode straight to
// the hand-over of their result.
// Reset clears the count and the output register; the memory needs no
// clearing because only positions below the count are ever returned.
// A stalled response is held in the output register while the next
// request is accepted and processed up to the point of handing over.
// ----------------------------------------------------------------------------
module indexed_list_store #(
   parameter int CAPACITY = ils_pkg::CAPACITY_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   ils_req_if.sink  req_chan,
   ils_rsp_if.source rsp_chan
);
   import ils_pkg::*;

   // Command bundle from the sequencer and status bundle back from the
   // datapath; these are the only signals between the two halves.
   ctrl_type ctrl;
   stat_type stat;

   ils_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // The datapath owns the element memory, the count, the captured request
   // and the output register that decouples the response side.
   ils_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_chan.cmd),
      .req_position   (req_chan.position),
      .req_value      (req_chan.value),
      .ctrl           (ctrl),
      .stat           (stat),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_status     (rsp_chan.status)
   );

endmodule

// ----- design/ils_checker.sv -----
// ----------------------------------------------------------------------------
// ils_checker: port-level checks for the indexed list store
// Watches the channel handshakes and result codes; bound to the top level.
// ----------------------------------------------------------------------------
module ils_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [ils_pkg::DATA_W-1:0] rsp_read_value,
   input logic [ils_pkg::STATUS_W-1:0]     rsp_status
);
   import ils_pkg::*;

   // A stalled response keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
                                && $stable(rsp_status))
      else $error("stalled response changed");

   // One transaction at a time: the request side closes after acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // Only the three defined status codes are reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_RANGE
                     || rsp_status == ST_FULL))
      else $error("undefined status code");

   // An insert refused as full carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_read_value == '0)
      else $error("full status with non-zero value");

   // Reset empties the output register.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_status     (rsp_chan.status)
);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the indexed list store
// Drives read, insert and delete commands through the request channel,
// predicts every response with a queue-based copy of the list, and checks
// each response field by field, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ils_pkg::*;

   localparam int LIST_CAPACITY = CAPACITY_DEFAULT;

   // Command codes that the block does not define; they must answer zero/done.
   localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 3'd5;
   localparam logic [CMD_W-1:0] CMD_LAST_CODE    = 3'd7;

   // The slowest transaction moves all but one entry of a full list, and on
   // top of that the sender may pause and the receiver may stall. The limit
   // on quiet cycles is that worst case taken several times over.
   localparam int WATCHDOG_LIMIT = 8 * (LIST_CAPACITY + 40);

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      logic [STATUS_W-1:0]      status;
   } result_type;

   logic clock;
   logic reset;

   ils_req_if req_chan ();
   ils_rsp_if rsp_chan ();

   indexed_list_store DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The predicted contents of the list, head first, and the responses
   // still owed by the block, oldest first.
   logic signed [DATA_W-1:0] list_model [$];
   result_type               owed_results [$];

   int failures     = 0;
   int quiet_cycles = 0;
   int stall_left   = 0;

   // Percentage chance that an idle burst starts on either channel. Zero
   // turns idling off.
   int idle_pct = 20;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // -------------------------------------------------------------------------
   // Prediction. Applies one accepted command to the list copy and returns
   // the response that the block must give for it. The order of the checks
   // for an insert at a position matters: a position beyond the count is
   // flagged as out of range even when the list is also full.
   // -------------------------------------------------------------------------
   function automatic result_type apply_command(input logic [CMD_W-1:0] c,
                                                input logic [POS_W-1:0] p,
                                                input logic signed [DATA_W-1:0] v);
      result_type r;
      int         n;
      n            = list_model.size();
      r.read_value = '0;
      r.status     = ST_DONE;
      case (c)
         CMD_READ: begin
            if (int'(p) >= n) begin
               r.read_value = -1;
               r.status     = ST_RANGE;
            end else begin
               r.read_value = list_model[p];
            end
         end
         CMD_INS_HEAD: begin
            if (n >= LIST_CAPACITY) r.status = ST_FULL;
            else list_model.push_front(v);
         end
         CMD_INS_TAIL: begin
            if (n >= LIST_CAPACITY) r.status = ST_FULL;
            else list_model.push_back(v);
         end
         CMD_INS_POS: begin
            if (int'(p) > n) r.status = ST_RANGE;
            else if (n >= LIST_CAPACITY) r.status = ST_FULL;
            else list_model.insert(int'(p), v);
         end
         CMD_DELETE: begin
            if (int'(p) >= n) r.status = ST_RANGE;
            else list_model.delete(int'(p));
         end
         default: begin
            // Unknown codes leave the list alone and answer zero with done.
         end
      endcase
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // Request side. Fields change on the falling edge; the transaction counts
   // as accepted at the first rising edge that sees valid and ready high.
   // Valid is left high afterwards, so that back-to-back commands never
   // lower and raise it within the same time step.
   // -------------------------------------------------------------------------
   task automatic send_command(input logic [CMD_W-1:0] c,
                               input logic [POS_W-1:0] p,
                               input logic signed [DATA_W-1:0] v);
      int gap;
      gap = 0;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
         gap = $urandom_range(1, 15);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid    <= 1'b1;
      req_chan.cmd      <= c;
      req_chan.position <= p;
      req_chan.value    <= v;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      owed_results.push_back(apply_command(c, p, v));
   endtask

   // One random command. grow_pct steers the list length: it is roughly the
   // share of well-formed commands that are inserts. A small share is noise:
   // unknown codes, and defined codes with a fully random position, which is
   // usually out of range and exercises the top bit of the position field.
   task automatic random_command(input int grow_pct);
      int                       roll;
      int                       n;
      logic [CMD_W-1:0]         c;
      logic [POS_W-1:0]         p;
      n    = list_model.size();
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         c = CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
         p = POS_W'($urandom);
      end else if (roll < 10) begin
         c = CMD_W'($urandom_range(CMD_READ, CMD_DELETE));
         p = POS_W'($urandom);
      end else if ($urandom_range(0, 99) < grow_pct) begin
         case ($urandom_range(0, 2))
            0:       c = CMD_INS_HEAD;
            1:       c = CMD_INS_TAIL;
            default: c = CMD_INS_POS;
         endcase
         p = POS_W'($urandom_range(0, n));
      end else begin
         c = $urandom_range(0, 1) ? CMD_READ : CMD_DELETE;
         p = (n == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, n - 1));
      end
      send_command(c, p, $urandom);
   endtask

   // -------------------------------------------------------------------------
   // Response side. Ready is driven on the falling edge, and dropped in random
   // stall bursts while idling is enabled.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= $urandom_range(0, 14);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Every response transaction is matched against the oldest owed result.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (owed_results.size() == 0) begin
            failures++;
            $display("%0t: unexpected response, expected none, got value %0d status %0d",
                     $time, rsp_chan.read_value, rsp_chan.status);
         end else begin
            want = owed_results.pop_front();
            if (rsp_chan.read_value !== want.read_value) begin
               failures++;
               $display("%0t: read_value mismatch, expected %0d, got %0d",
                        $time, want.read_value, rsp_chan.read_value);
            end
            if (rsp_chan.status !== want.status) begin
               failures++;
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_chan.status);
            end
         end
      end
   end

   // Watchdog: any transaction on either channel shows the block is alive.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Short directed run over an empty and a small list: the extreme values,
   // every command, reads, deletes and inserts just past the end of the list,
   // and the three unknown command codes.
   task automatic test_directed_edges();
      send_command(CMD_READ, '0, $urandom);           // read of an empty list
      send_command(CMD_READ, '1, $urandom);           // highest position
      send_command(CMD_DELETE, '0, $urandom);         // delete from empty list
      send_command(CMD_INS_POS, POS_W'(1), 32'sd5);   // one past the end
      send_command(CMD_INS_POS, '0, 32'sh8000_0000);  // most negative value
      send_command(CMD_INS_HEAD, '0, 32'sh7FFF_FFFF); // most positive value
      send_command(CMD_INS_TAIL, '1, -32'sd1);        // position is ignored
      send_command(CMD_INS_POS, POS_W'(3), '0);       // insert at the count
      send_command(CMD_INS_POS, POS_W'(2), 32'sd12345);
      for (int i = 0; i < 5; i++)
         send_command(CMD_READ, POS_W'(i), $urandom);
      send_command(CMD_READ, POS_W'(5), '0);          // read at the count
      send_command(CMD_DELETE, POS_W'(5), '0);        // delete at the count
      send_command(CMD_INS_POS, POS_W'(6), 32'sd1);   // insert past the count
      for (int k = int'(CMD_FIRST_UNUSED); k <= int'(CMD_LAST_CODE); k++)
         send_command(CMD_W'(k), POS_W'($urandom), $urandom);
      send_command(CMD_DELETE, POS_W'(4), '0);        // last entry
      send_command(CMD_DELETE, '0, '0);               // first entry
      send_command(CMD_READ, '0, '0);
      send_command(CMD_READ, POS_W'(2), '0);
   endtask

   // Random commands on a short list, with the idling level changed every
   // hundred commands so that some stretches run without any pauses.
   task automatic test_short_list_mix(input int count);
      int grow;
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            case ((i / 100) % 3)
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               default: idle_pct = 40;
            endcase
         end
         grow = (list_model.size() > 32) ? 35 : 55;
         random_command(grow);
      end
   endtask

   // Fill the list to capacity with random inserts, probe the full list,
   // wander around the full mark for a while and then drain it to empty.
   task automatic test_full_list();
      idle_pct = 15;
      while (list_model.size() < LIST_CAPACITY) begin
         case ($urandom_range(0, 2))
            0:       send_command(CMD_INS_HEAD, POS_W'($urandom), $urandom);
            1:       send_command(CMD_INS_TAIL, POS_W'($urandom), $urandom);
            default: send_command(CMD_INS_POS,
                                  POS_W'($urandom_range(0, list_model.size())), $urandom);
         endcase
      end
      // Refused inserts of every kind; past the count the range check wins.
      send_command(CMD_INS_HEAD, '0, $urandom);
      send_command(CMD_INS_TAIL, '0, $urandom);
      send_command(CMD_INS_POS, '0, $urandom);
      send_command(CMD_INS_POS, POS_W'(LIST_CAPACITY), $urandom);
      send_command(CMD_INS_POS, POS_W'(LIST_CAPACITY + 1), $urandom);
      send_command(CMD_INS_POS, '1, $urandom);
      send_command(CMD_READ, POS_W'(LIST_CAPACITY - 1), '0);
      send_command(CMD_READ, POS_W'(LIST_CAPACITY), '0);
      send_command(CMD_DELETE, POS_W'(LIST_CAPACITY), '0);
      for (int i = 0; i < 50; i++)
         random_command(60);
      while (list_model.size() != 0) begin
         if ($urandom_range(0, 3) == 0)
            send_command(CMD_READ, POS_W'($urandom_range(0, list_model.size() - 1)), '0);
         send_command(CMD_DELETE, POS_W'($urandom_range(0, list_model.size() - 1)), $urandom);
      end
   endtask

   // Closing stretch with both channels running flat out.
   task automatic test_full_rate(input int count);
      idle_pct = 0;
      for (int i = 0; i < count; i++)
         random_command((list_model.size() > 32) ? 35 : 55);
   endtask

   initial begin
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.cmd      = '0;
      req_chan.position = '0;
      req_chan.value    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_short_list_mix(600);
      test_full_list();
      test_full_rate(300);

      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Drain the owed responses, then give the block time to show anything
      // spurious; the watchdog bounds both waits.
      while (owed_results.size() != 0) @(posedge clock);
      repeat (2 * LIST_CAPACITY) @(posedge clock);

      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/ils_pkg.sv
design/ils_channels.sv
design/ils_datapath.sv
design/ils_controller.sv
design/indexed_list_store.sv
design/ils_checker.sv
bench/tb.sv
